// ===== rtl/core/irpdd_pkg.sv =====
// Shared types, constants and the control program of the IR pulse-duration decoder.
package irpdd_pkg;

  // Field widths
  localparam int unsigned DUR_W      = 20;
  localparam int unsigned CODE_W     = 32;
  localparam int unsigned BIT_TIME_W = 16;
  localparam int unsigned LEFT_W     = 6;
  localparam int unsigned CFG_ADDR_W = 2;
  localparam int unsigned DIV_CNT_W  = 5;
  localparam int unsigned PC_W       = 4;

  // Parameter defaults
  localparam int unsigned STORE_DEPTH_DEF    = 32;
  localparam int unsigned DECODE_ENTRIES_DEF = 16;
  localparam int unsigned CODE_BITS_DEF      = 32;

  // Register reset values
  localparam logic [CODE_W-1:0]     STOP_CODE_RST = 32'hF3E7_C300;
  localparam logic [BIT_TIME_W-1:0] BIT_TIME_RST  = 16'd550;
  localparam logic [DUR_W-1:0]      START_THR_RST = 20'd5000;

  // Register indexes
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_STOP_CODE = 2'd0,
    REG_BIT_TIME  = 2'd1,
    REG_START_THR = 2'd2
  } cfg_reg_e;

  // Request types
  typedef enum logic {
    REQ_RECORD = 1'b0,
    REQ_DECODE = 1'b1
  } req_e;

  // Channel words
  typedef struct packed {
    logic             req_type;
    logic [DUR_W-1:0] pulse_us;
    logic             pulse_level;
  } in_word_t;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              is_stop;
    logic              frame_armed;
  } out_word_t;

  typedef struct packed {
    logic [CFG_ADDR_W-1:0] addr;
    logic [CODE_W-1:0]     wdata;
  } cfg_word_t;

  // Datapath operations
  typedef enum logic [3:0] {
    UOP_NOP,
    UOP_FETCH,
    UOP_RECORD,
    UOP_CLEAR,
    UOP_READ,
    UOP_DIV_LOAD,
    UOP_DIV_STEP,
    UOP_MERGE,
    UOP_PUSH
  } uop_e;

  // Jump conditions
  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NO_ITEM,
    COND_IS_DECODE,
    COND_NOT_ARMED,
    COND_DIV_MORE,
    COND_MORE_ENT,
    COND_OUT_FULL
  } cond_e;

  typedef struct packed {
    uop_e            op;
    cond_e           cond;
    logic [PC_W-1:0] target;
  } uword_t;

  // Sequencer to datapath
  typedef struct packed {
    uop_e op;
  } ctrl_t;

  // Datapath to sequencer
  typedef struct packed {
    logic item_valid;
    logic is_decode;
    logic armed;
    logic div_more;
    logic more_ent;
    logic out_full;
  } stat_t;

  // Control program
  function automatic uword_t ucode(input logic [PC_W-1:0] pc);
    uword_t w;
    unique case (pc)
      4'd0:    w = '{UOP_FETCH,    COND_NO_ITEM,   4'd0};
      4'd1:    w = '{UOP_NOP,      COND_IS_DECODE, 4'd3};
      4'd2:    w = '{UOP_RECORD,   COND_ALWAYS,    4'd0};
      4'd3:    w = '{UOP_CLEAR,    COND_NOT_ARMED, 4'd8};
      4'd4:    w = '{UOP_READ,     COND_NEVER,     4'd0};
      4'd5:    w = '{UOP_DIV_LOAD, COND_NEVER,     4'd0};
      4'd6:    w = '{UOP_DIV_STEP, COND_DIV_MORE,  4'd6};
      4'd7:    w = '{UOP_MERGE,    COND_MORE_ENT,  4'd4};
      4'd8:    w = '{UOP_PUSH,     COND_OUT_FULL,  4'd8};
      default: w = '{UOP_NOP,      COND_ALWAYS,    4'd0};
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/core/irpdd_chan_if.sv =====
// Valid/ready channel carrying one word of a given type.
interface irpdd_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/irpdd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module irpdd_ram #(
  parameter int unsigned WIDTH = 20,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/irpdd_div.sv =====
// Restoring divider, one quotient bit per cycle while step_i is high.
module irpdd_div (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             load_i,
  input  logic                             step_i,
  input  logic [irpdd_pkg::DUR_W-1:0]      dividend_i,
  input  logic [irpdd_pkg::BIT_TIME_W-1:0] divisor_i,
  output logic [irpdd_pkg::DUR_W-1:0]      quotient_o,
  output logic                             more_o
);

  localparam int unsigned DW = irpdd_pkg::DUR_W;
  localparam int unsigned BW = irpdd_pkg::BIT_TIME_W;
  localparam int unsigned CW = irpdd_pkg::DIV_CNT_W;

  logic [BW-1:0] rem_q, rem_d;
  logic [DW-1:0] quo_q, quo_d;
  logic [BW-1:0] dvs_q;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [BW:0]   shifted;
  logic [BW+1:0] diff;

  // Trial subtract of the divisor from the shifted remainder
  always_comb begin
    shifted = {rem_q, quo_q[DW-1]};
    diff    = {1'b0, shifted} - {2'b00, dvs_q};
    rem_d   = rem_q;
    quo_d   = quo_q;
    cnt_d   = cnt_q;
    if (load_i) begin
      rem_d = '0;
      quo_d = dividend_i;
      cnt_d = CW'(DW);
    end else if (step_i) begin
      rem_d = diff[BW+1] ? shifted[BW-1:0] : diff[BW-1:0];
      quo_d = {quo_q[DW-2:0], ~diff[BW+1]};
      cnt_d = cnt_q - CW'(1);
    end
  end

  // Hold the step count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // Hold remainder, quotient and divisor
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (load_i) begin
      dvs_q <= (divisor_i == '0) ? BW'(1) : divisor_i;
    end
  end

  assign quotient_o = quo_q;
  assign more_o     = (cnt_q != CW'(1));

endmodule

// ===== rtl/core/irpdd_useq.sv =====
// Program counter and control store of the decoder.
module irpdd_useq (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  irpdd_pkg::stat_t stat_i,
  output irpdd_pkg::ctrl_t ctrl_o
);

  localparam int unsigned PW = irpdd_pkg::PC_W;

  logic [PW-1:0]     pc_q, pc_d;
  irpdd_pkg::uword_t uw;
  logic              take;

  // Decode the current control word and pick the next step
  always_comb begin
    uw = irpdd_pkg::ucode(pc_q);
    unique case (uw.cond)
      irpdd_pkg::COND_NEVER:     take = 1'b0;
      irpdd_pkg::COND_ALWAYS:    take = 1'b1;
      irpdd_pkg::COND_NO_ITEM:   take = ~stat_i.item_valid;
      irpdd_pkg::COND_IS_DECODE: take = stat_i.is_decode;
      irpdd_pkg::COND_NOT_ARMED: take = ~stat_i.armed;
      irpdd_pkg::COND_DIV_MORE:  take = stat_i.div_more;
      irpdd_pkg::COND_MORE_ENT:  take = stat_i.more_ent;
      irpdd_pkg::COND_OUT_FULL:  take = stat_i.out_full;
      default:                   take = 1'b1;
    endcase
    pc_d      = take ? uw.target : pc_q + PW'(1);
    ctrl_o.op = uw.op;
  end

  // Advance the step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= '0;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

// ===== rtl/core/irpdd_dp.sv =====
// Datapath: settings, pulse store, code builder and result register.
module irpdd_dp #(
  parameter int unsigned STORE_DEPTH    = irpdd_pkg::STORE_DEPTH_DEF,
  parameter int unsigned DECODE_ENTRIES = irpdd_pkg::DECODE_ENTRIES_DEF,
  parameter int unsigned CODE_BITS      = irpdd_pkg::CODE_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  irpdd_pkg::ctrl_t  ctrl_i,
  output irpdd_pkg::stat_t  stat_o,
  irpdd_chan_if.sink        pulse_i,
  irpdd_chan_if.source      result_o,
  irpdd_chan_if.sink        cfg_i
);

  localparam int unsigned DW = irpdd_pkg::DUR_W;
  localparam int unsigned CW = irpdd_pkg::CODE_W;
  localparam int unsigned BW = irpdd_pkg::BIT_TIME_W;
  localparam int unsigned LW = irpdd_pkg::LEFT_W;
  localparam int unsigned AW = $clog2(STORE_DEPTH);
  localparam int unsigned IW = $clog2(STORE_DEPTH + 1);
  localparam int unsigned EW = $clog2(DECODE_ENTRIES + 1);

  // Settings
  logic [CW-1:0] stop_code_q;
  logic [BW-1:0] bit_time_q;
  logic [DW-1:0] start_thr_q;

  // Frame state
  logic                   armed_q;
  logic [IW-1:0]          widx_q;
  logic [STORE_DEPTH-1:0] valid_q;

  // Latched item
  logic          req_q;
  logic [DW-1:0] dur_q;
  logic          lvl_q;

  // Code builder
  logic [CW-1:0] code_q;
  logic [LW-1:0] left_q;
  logic          level_q;
  logic [EW-1:0] ent_q;
  logic          rd_ok_q;

  // Result register
  logic                 out_valid_q;
  irpdd_pkg::out_word_t out_q;

  logic          accept;
  logic          rec_en, wr_en, push;
  logic [AW-1:0] rd_addr;
  logic [DW-1:0] rdata;
  logic [DW-1:0] quot;
  logic          div_more;
  logic [LW-1:0] n_bits;
  logic [LW-1:0] low_pos;
  logic [CW-1:0] mask;

  assign accept  = pulse_i.valid && pulse_i.ready;
  assign rec_en  = (ctrl_i.op == irpdd_pkg::UOP_RECORD);
  assign wr_en   = rec_en && armed_q && (widx_q != IW'(STORE_DEPTH));
  assign push    = (ctrl_i.op == irpdd_pkg::UOP_PUSH) && !stat_o.out_full;
  assign rd_addr = AW'(ent_q);

  // Handshakes
  assign pulse_i.ready  = (ctrl_i.op == irpdd_pkg::UOP_FETCH);
  assign cfg_i.ready    = 1'b1;
  assign result_o.valid = out_valid_q;
  assign result_o.data  = out_q;

  // Status for the sequencer
  assign stat_o.item_valid = pulse_i.valid;
  assign stat_o.is_decode  = (req_q == irpdd_pkg::REQ_DECODE);
  assign stat_o.armed      = armed_q;
  assign stat_o.div_more   = div_more;
  assign stat_o.more_ent   = (ent_q != EW'(DECODE_ENTRIES - 1));
  assign stat_o.out_full   = out_valid_q && !result_o.ready;

  // Settings registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stop_code_q <= irpdd_pkg::STOP_CODE_RST;
      bit_time_q  <= irpdd_pkg::BIT_TIME_RST;
      start_thr_q <= irpdd_pkg::START_THR_RST;
    end else if (cfg_i.valid) begin
      case (irpdd_pkg::cfg_reg_e'(cfg_i.data.addr))
        irpdd_pkg::REG_STOP_CODE: stop_code_q <= cfg_i.data.wdata;
        irpdd_pkg::REG_BIT_TIME:  bit_time_q  <= cfg_i.data.wdata[BW-1:0];
        irpdd_pkg::REG_START_THR: start_thr_q <= cfg_i.data.wdata[DW-1:0];
        default: ;
      endcase
    end
  end

  // Latch the accepted word
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= pulse_i.data.req_type;
      dur_q <= pulse_i.data.pulse_us;
      lvl_q <= pulse_i.data.pulse_level;
    end
  end

  // Arm, count stored pulses and mark written entries; drop on decode
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q <= 1'b0;
      widx_q  <= '0;
      valid_q <= '0;
    end else if (push) begin
      armed_q <= 1'b0;
      widx_q  <= '0;
    end else if (wr_en) begin
      widx_q                <= widx_q + IW'(1);
      valid_q[AW'(widx_q)]  <= 1'b1;
    end else if (rec_en && !armed_q && lvl_q && (dur_q > start_thr_q)) begin
      armed_q <= 1'b1;
    end
  end

  irpdd_ram #(
    .WIDTH (DW),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (AW'(widx_q)),
    .wdata_i (dur_q),
    .re_i    (ctrl_i.op == irpdd_pkg::UOP_READ),
    .raddr_i (rd_addr),
    .rdata_o (rdata)
  );

  irpdd_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (ctrl_i.op == irpdd_pkg::UOP_DIV_LOAD),
    .step_i     (ctrl_i.op == irpdd_pkg::UOP_DIV_STEP),
    .dividend_i (rd_ok_q ? rdata : '0),
    .divisor_i  (bit_time_q),
    .quotient_o (quot),
    .more_o     (div_more)
  );

  // Clip the bit count and build the run mask at the top of the free positions
  always_comb begin
    n_bits  = (quot > DW'(left_q)) ? left_q : quot[LW-1:0];
    low_pos = left_q - n_bits;
    for (int i = 0; i < CW; i++) begin
      mask[i] = (LW'(i) < left_q) && (LW'(i) >= low_pos);
    end
  end

  // Walk the entries and fill the code
  always_ff @(posedge clk_i) begin
    unique case (ctrl_i.op)
      irpdd_pkg::UOP_CLEAR: begin
        code_q  <= '0;
        left_q  <= LW'(CODE_BITS);
        level_q <= 1'b1;
        ent_q   <= '0;
      end
      irpdd_pkg::UOP_READ: begin
        rd_ok_q <= (32'(ent_q) < STORE_DEPTH) && valid_q[rd_addr];
      end
      irpdd_pkg::UOP_MERGE: begin
        if (level_q) begin
          code_q <= code_q | mask;
        end
        left_q  <= low_pos;
        level_q <= ~level_q;
        ent_q   <= ent_q + EW'(1);
      end
      default: ;
    endcase
  end

  // Result register: free it when taken, load it on push
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (push) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      out_q.code        <= armed_q ? code_q : '0;
      out_q.is_stop     <= armed_q && (code_q == stop_code_q);
      out_q.frame_armed <= armed_q;
    end
  end

endmodule

// ===== rtl/core/ir_pulse_duration_decoder.sv =====
// Top level of the IR pulse-duration decoder.
//
// Takes pulse words (duration in us, pin level) and decode requests on
// pulse_i, one word at a time, and returns one result word per decode request
// on result_o. A recorded pulse is fetched, checked and recorded before the
// next word can be taken. For a decode request of an armed frame, each entry
// is read from the pulse store and divided by the bit time in a restoring
// divider that yields one quotient bit per cycle over the 20 duration bits.
// A decode while not armed skips the entries. The result sits in an output
// register, so the next pulse is accepted while it waits to be taken; a further
// decode that finishes while it still waits holds the input until it is taken.
// Settings on cfg_i (0 stop code, 1 bit time, 2 start threshold) are always
// accepted; write them only while the block is idle.
module ir_pulse_duration_decoder #(
  parameter int unsigned STORE_DEPTH    = irpdd_pkg::STORE_DEPTH_DEF,
  parameter int unsigned DECODE_ENTRIES = irpdd_pkg::DECODE_ENTRIES_DEF,
  parameter int unsigned CODE_BITS      = irpdd_pkg::CODE_BITS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  irpdd_chan_if.sink   pulse_i,
  irpdd_chan_if.source result_o,
  irpdd_chan_if.sink   cfg_i
);

  irpdd_pkg::ctrl_t ctrl;
  irpdd_pkg::stat_t stat;

  // Control program sequencer
  irpdd_useq u_useq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  // Datapath driven by the control word
  irpdd_dp #(
    .STORE_DEPTH    (STORE_DEPTH),
    .DECODE_ENTRIES (DECODE_ENTRIES),
    .CODE_BITS      (CODE_BITS)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .stat_o   (stat),
    .pulse_i  (pulse_i),
    .result_o (result_o),
    .cfg_i    (cfg_i)
  );

endmodule

// ===== tb/ir_pulse_duration_decoder_tb.sv =====
// Self-checking testbench of the IR pulse-duration decoder: directed table, then random frames.
`timescale 1ns / 100ps

module ir_pulse_duration_decoder_tb;

  localparam int unsigned STORE_DEPTH    = irpdd_pkg::STORE_DEPTH_DEF;
  localparam int unsigned DECODE_ENTRIES = irpdd_pkg::DECODE_ENTRIES_DEF;
  localparam int unsigned CODE_BITS      = irpdd_pkg::CODE_BITS_DEF;
  localparam int unsigned DUR_W          = irpdd_pkg::DUR_W;
  localparam int unsigned CODE_W         = irpdd_pkg::CODE_W;
  localparam int unsigned BIT_TIME_W     = irpdd_pkg::BIT_TIME_W;
  localparam int unsigned DUR_MAX        = (1 << DUR_W) - 1;
  localparam int unsigned IDLE_PAD       = 12;
  localparam int unsigned HOLD_CYCLES    = 3000;
  localparam int unsigned STALL_LIMIT    = 20000;
  localparam int unsigned PHASE_WORDS    = 280;
  localparam int unsigned NUM_PHASES     = 6;

  // One row of the directed table; the typed result is used only where typed_ok is set
  typedef struct {
    irpdd_pkg::req_e   req;
    int unsigned       dur;
    bit                lvl;
    bit                typed_ok;
    logic [CODE_W-1:0] code;
    bit                is_stop;
    bit                armed;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  irpdd_chan_if #(.T(irpdd_pkg::in_word_t))  pulse_ch ();
  irpdd_chan_if #(.T(irpdd_pkg::out_word_t)) result_ch ();
  irpdd_chan_if #(.T(irpdd_pkg::cfg_word_t)) cfg_ch ();

  ir_pulse_duration_decoder dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .pulse_i  (pulse_ch),
    .result_o (result_ch),
    .cfg_i    (cfg_ch)
  );

  // Directed words at reset settings: threshold edges, saturated pulses, the stop code
  // built from runs of 4,2,5,2,5,4,2,8 bits, stale store entries, zero duration
  stim_row_t dir_rows [24] = '{
    '{irpdd_pkg::REQ_DECODE, 0,       1'b0, 1'b1, 32'h0000_0000, 1'b0, 1'b0},
    '{irpdd_pkg::REQ_RECORD, 5000,    1'b1, 1'b0, '0, 1'b0, 1'b0},
    '{irpdd_pkg::REQ_RECORD, DUR_MAX, 1'b0, 1'b0, '0, 1'b0, 1'b0},
    '{irpdd_pkg::REQ_DECODE, 0,       1'b0, 1'b1, 32'h0000_0000, 1'b0, 1'b0},
    '{irpdd_pkg::REQ_RECORD, 5001,    1'b1, 1'b0, '0, 1'b0, 1'b0},
    '{irpdd_pkg::REQ_RECORD, DUR_MAX, 1'b1, 1'b0, '0, 1'b0, 1'b0},
    '{irpdd_pkg::REQ_DECODE, 0,       1'b0, 1'b1, 32'hFFFF_FFFF, 1'b0, 1'b1},
    '{irpdd_pkg::REQ_RECORD, DUR_MAX, 1'b1, 1'b0, '0, 1'b0, 1'b0},
    '{irpdd_pkg::REQ_RECORD, 2200,    1'b0, 1'b0, '0, 1'b0, 1'b0},
    '{irpdd_pkg::REQ_RECORD, 1100,    1'b1, 1'b0, '0, 1'b0, 1'b0},
    '{irpdd_pkg::REQ_RECORD, 2750,    1'b0, 1'b0, '0, 1'b0, 1'b0},
    '{irpdd_pkg::REQ_RECORD, 1100,    1'b1, 1'b0, '0, 1'b0, 1'b0},
    '{irpdd_pkg::REQ_RECORD, 2750,    1'b0, 1'b0, '0, 1'b0, 1'b0},
    '{irpdd_pkg::REQ_RECORD, 2200,    1'b1, 1'b0, '0, 1'b0, 1'b0},
    '{irpdd_pkg::REQ_RECORD, 1100,    1'b0, 1'b0, '0, 1'b0, 1'b0},
    '{irpdd_pkg::REQ_RECORD, 4400,    1'b1, 1'b0, '0, 1'b0, 1'b0},
    '{irpdd_pkg::REQ_DECODE, 0,       1'b1, 1'b0, '0, 1'b0, 1'b0},
    '{irpdd_pkg::REQ_RECORD, 6000,    1'b1, 1'b0, '0, 1'b0, 1'b0},
    '{irpdd_pkg::REQ_DECODE, 0,       1'b0, 1'b0, '0, 1'b0, 1'b0},
    '{irpdd_pkg::REQ_RECORD, 0,       1'b0, 1'b0, '0, 1'b0, 1'b0},
    '{irpdd_pkg::REQ_DECODE, 0,       1'b1, 1'b1, 32'h0000_0000, 1'b0, 1'b0},
    '{irpdd_pkg::REQ_RECORD, 5001,    1'b1, 1'b0, '0, 1'b0, 1'b0},
    '{irpdd_pkg::REQ_RECORD, 0,       1'b1, 1'b0, '0, 1'b0, 1'b0},
    '{irpdd_pkg::REQ_DECODE, DUR_MAX, 1'b1, 1'b0, '0, 1'b0, 1'b0}
  };

  // Shadow copy of the block's settings and frame state
  logic [CODE_W-1:0]     shadow_stop;
  logic [BIT_TIME_W-1:0] shadow_bit_time;
  logic [DUR_W-1:0]      shadow_thr;
  bit                    shadow_armed;
  logic [DUR_W-1:0]      shadow_store [STORE_DEPTH];
  int unsigned           shadow_count;

  irpdd_pkg::out_word_t pending_decodes [$];
  irpdd_pkg::out_word_t oldest_decode;
  int unsigned mismatch_count;
  int unsigned words_sent;
  int unsigned burst_left;
  int unsigned quiet_cycles;
  int unsigned hold_left;
  int unsigned window_left;
  int unsigned stall_pct;
  bit          hold_go;

  always #6 clk_i = ~clk_i;

  // Expand the first stored durations into runs of alternating level, MSB first
  function automatic logic [CODE_W-1:0] assemble_code();
    int unsigned divisor;
    int unsigned left;
    int unsigned n;
    int unsigned dur;
    logic [63:0] acc;
    bit          lvl;
    divisor = (shadow_bit_time == 0) ? 1 : shadow_bit_time;
    left    = CODE_BITS;
    acc     = '0;
    lvl     = 1'b1;
    for (int i = 0; i < DECODE_ENTRIES; i++) begin
      dur = (i < STORE_DEPTH) ? shadow_store[i] : 0;
      n   = dur / divisor;
      if (n > left) n = left;
      if (n > 0 && lvl) acc |= ((64'd1 << n) - 64'd1) << (left - n);
      left -= n;
      lvl   = !lvl;
    end
    return acc[CODE_W-1:0];
  endfunction

  // Advance the shadow state by one accepted pulse word
  function automatic void apply_pulse_word(input irpdd_pkg::in_word_t w,
                                           output bit produces,
                                           output irpdd_pkg::out_word_t res);
    res      = '0;
    produces = 1'b0;
    if (w.req_type == irpdd_pkg::REQ_RECORD) begin
      if (shadow_armed) begin
        if (shadow_count < STORE_DEPTH) begin
          shadow_store[shadow_count] = w.pulse_us;
          shadow_count++;
        end
      end else if (w.pulse_us > shadow_thr && w.pulse_level) begin
        shadow_armed = 1'b1;
      end
    end else begin
      produces = 1'b1;
      if (shadow_armed) begin
        res.code        = assemble_code();
        res.is_stop     = (res.code == shadow_stop);
        res.frame_armed = 1'b1;
        shadow_count    = 0;
        shadow_armed    = 1'b0;
      end
    end
  endfunction

  task automatic flag_mismatch(input string what, input logic [CODE_W-1:0] got,
                               input logic [CODE_W-1:0] want);
    $display("mismatch at %0t: %s got 0x%08h want 0x%08h", $time, what, got, want);
    mismatch_count++;
  endtask

  // Offer one word in bursts with random gaps; predict on acceptance
  task automatic send_pulse_word(input irpdd_pkg::in_word_t w, input bit typed_ok,
                                 input irpdd_pkg::out_word_t typed_res);
    bit                   produces;
    irpdd_pkg::out_word_t res;
    if (burst_left == 0) begin
      pulse_ch.valid = 1'b0;
      repeat ($urandom_range(1, 24)) @(negedge clk_i);
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    pulse_ch.valid = 1'b1;
    pulse_ch.data  = w;
    do @(posedge clk_i); while (!pulse_ch.ready);
    apply_pulse_word(w, produces, res);
    if (produces) pending_decodes.push_back(typed_ok ? typed_res : res);
    words_sent++;
    @(negedge clk_i);
  endtask

  // Hold the sender until every decode has come back, then let the block settle
  task automatic wait_drained();
    pulse_ch.valid = 1'b0;
    while (pending_decodes.size() != 0) @(negedge clk_i);
    repeat (IDLE_PAD) @(negedge clk_i);
  endtask

  task automatic write_reg(input irpdd_pkg::cfg_reg_e idx, input logic [CODE_W-1:0] value);
    cfg_ch.valid = 1'b1;
    cfg_ch.data  = {idx, value};
    do @(posedge clk_i); while (!cfg_ch.ready);
    case (idx)
      irpdd_pkg::REG_STOP_CODE: shadow_stop     = value;
      irpdd_pkg::REG_BIT_TIME:  shadow_bit_time = value[BIT_TIME_W-1:0];
      irpdd_pkg::REG_START_THR: shadow_thr      = value[DUR_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic write_settings(input logic [CODE_W-1:0] stop, input int unsigned bit_time,
                                input int unsigned thr);
    write_reg(irpdd_pkg::REG_STOP_CODE, stop);
    write_reg(irpdd_pkg::REG_BIT_TIME, CODE_W'(bit_time));
    write_reg(irpdd_pkg::REG_START_THR, CODE_W'(thr));
    cfg_ch.valid = 1'b0;
  endtask

  // One frame: noise, a start pulse, durations near bit-time multiples, mostly a decode
  task automatic send_random_frame();
    irpdd_pkg::in_word_t  w;
    irpdd_pkg::out_word_t none;
    int unsigned eff_bit;
    int unsigned body_len;
    int unsigned dur;
    none    = '0;
    eff_bit = (shadow_bit_time == 0) ? 1 : shadow_bit_time;
    repeat ($urandom_range(0, 2)) begin
      w.pulse_level = 1'($urandom_range(0, 1));
      w.req_type    = ($urandom_range(0, 7) == 0) ? irpdd_pkg::REQ_DECODE
                                                  : irpdd_pkg::REQ_RECORD;
      dur           = w.pulse_level ? $urandom_range(0, shadow_thr) : $urandom;
      w.pulse_us    = DUR_W'(dur);
      send_pulse_word(w, 1'b0, none);
    end
    if (shadow_thr < DUR_MAX) begin
      w.req_type    = irpdd_pkg::REQ_RECORD;
      w.pulse_level = 1'b1;
      w.pulse_us    = DUR_W'($urandom_range(shadow_thr + 1, DUR_MAX));
      send_pulse_word(w, 1'b0, none);
    end
    case ($urandom_range(0, 19))
      0, 1, 2: body_len = $urandom_range(28, 40);
      3:       body_len = 0;
      default: body_len = $urandom_range(1, 20);
    endcase
    repeat (body_len) begin
      w.req_type    = irpdd_pkg::REQ_RECORD;
      w.pulse_level = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 99) < 85)
        dur = $urandom_range(0, 6) * eff_bit + $urandom_range(0, eff_bit - 1);
      else
        dur = $urandom;
      if (dur > DUR_MAX) dur = DUR_MAX;
      w.pulse_us = DUR_W'(dur);
      send_pulse_word(w, 1'b0, none);
    end
    // leave the odd frame open so the next start pulse lands in the store
    if ($urandom_range(0, 14) != 0) begin
      w.req_type    = irpdd_pkg::REQ_DECODE;
      w.pulse_us    = DUR_W'($urandom);
      w.pulse_level = 1'($urandom_range(0, 1));
      send_pulse_word(w, 1'b0, none);
    end
  endtask

  // Stall the result side on a pattern of its own, or for a long counted stretch
  always @(negedge clk_i) begin
    if (hold_go) begin
      hold_left = HOLD_CYCLES;
      hold_go   = 1'b0;
    end
    if (hold_left != 0) begin
      result_ch.ready = 1'b0;
      hold_left--;
    end else begin
      if (window_left == 0) begin
        window_left = $urandom_range(16, 96);
        stall_pct   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(20, 85);
      end
      window_left--;
      result_ch.ready = ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Compare each result word with the oldest predicted decode
  always @(posedge clk_i) begin
    if (rst_ni && result_ch.valid && result_ch.ready) begin
      if (pending_decodes.size() == 0) begin
        flag_mismatch("result with none pending, code", result_ch.data.code, '0);
      end else begin
        oldest_decode = pending_decodes.pop_front();
        if (result_ch.data.code !== oldest_decode.code)
          flag_mismatch("code", result_ch.data.code, oldest_decode.code);
        if (result_ch.data.is_stop !== oldest_decode.is_stop)
          flag_mismatch("is_stop", CODE_W'(result_ch.data.is_stop),
                        CODE_W'(oldest_decode.is_stop));
        if (result_ch.data.frame_armed !== oldest_decode.frame_armed)
          flag_mismatch("frame_armed", CODE_W'(result_ch.data.frame_armed),
                        CODE_W'(oldest_decode.frame_armed));
      end
    end
  end

  // Drop the run if no word moves on any channel for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (pulse_ch.valid && pulse_ch.ready) ||
        (result_ch.valid && result_ch.ready) || (cfg_ch.valid && cfg_ch.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    irpdd_pkg::in_word_t  w;
    irpdd_pkg::out_word_t typed_res;
    int unsigned phase_goal;
    rst_ni          = 1'b0;
    pulse_ch.valid  = 1'b0;
    pulse_ch.data   = '0;
    result_ch.ready = 1'b0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.data     = '0;
    hold_go         = 1'b0;
    hold_left       = 0;
    window_left     = 0;
    stall_pct       = 0;
    burst_left      = 0;
    quiet_cycles    = 0;
    mismatch_count  = 0;
    words_sent      = 0;
    shadow_stop     = irpdd_pkg::STOP_CODE_RST;
    shadow_bit_time = irpdd_pkg::BIT_TIME_RST;
    shadow_thr      = irpdd_pkg::START_THR_RST;
    shadow_armed    = 1'b0;
    shadow_count    = 0;
    foreach (shadow_store[i]) shadow_store[i] = '0;

    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Walk the directed table at reset settings
    foreach (dir_rows[r]) begin
      w.req_type            = dir_rows[r].req;
      w.pulse_us            = DUR_W'(dir_rows[r].dur);
      w.pulse_level         = dir_rows[r].lvl;
      typed_res.code        = dir_rows[r].code;
      typed_res.is_stop     = dir_rows[r].is_stop;
      typed_res.frame_armed = dir_rows[r].armed;
      send_pulse_word(w, dir_rows[r].typed_ok, typed_res);
    end
    wait_drained();

    // Random frames under several settings, extremes first
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0: write_settings($urandom, 1, 0);
        1: write_settings('0, 16'hFFFF, DUR_MAX);
        2: write_settings(32'hFFFF_FFFF, 0, $urandom_range(0, 20000));
        3: write_settings('0, $urandom_range(300, 700), irpdd_pkg::START_THR_RST);
        default: write_settings($urandom, $urandom_range(1, 3000), $urandom_range(0, 100000));
      endcase
      // hold the result side off long enough for the input to back up
      if (phase == 3) hold_go = 1'b1;
      phase_goal = words_sent + ((phase == 1) ? 60 : PHASE_WORDS);
      while (words_sent < phase_goal) send_random_frame();
      wait_drained();
    end

    if (pending_decodes.size() != 0)
      flag_mismatch("decodes left pending", CODE_W'(pending_decodes.size()), '0);
    if (mismatch_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
